@@ rtl/rqpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rqpd_pkg: shared types and constants of the ready queue
// Transaction payloads, queue entry layout, status and policy codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rqpd_pkg;

	// Configuration port: one register, addressed by byte.
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_POLICY = 1'b0;

	// Dispatch policy codes. The unused code behaves as oldest first.
	localparam logic [1:0] POL_OLDEST   = 2'd0;
	localparam logic [1:0] POL_SHORTEST = 2'd1;
	localparam logic [1:0] POL_PRIO     = 2'd2;

	localparam logic OP_ENQ  = 1'b0;
	localparam logic OP_DISP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  proc_id;
		logic [15:0] est_clocks;
		logic [7:0]  prio_level;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_id;
		logic [15:0] out_clocks;
		logic [7:0]  out_prio;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] clocks;
		logic [7:0]  prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_FETCH,
		S_FETCH_W,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    enq_wr;
		logic    res_st_ld;
		status_t res_status;
		logic    ptr_clr;
		logic    rd_step;
		logic    cmp;
		logic    cmp_min;
		logic    fetch_rd;
		logic    res_ld;
		logic    shift_wr;
		logic    dec;
		logic    out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic ptr_lt_fill;
		logic pv;
	} dp_stat_t;

endpackage

@@ rtl/rqpd_dp.sv @@
// ----------------------------------------------------------------------------
// rqpd_dp: ready queue datapath
// Entry memory, fill count, scan pointer with compare, compaction and the
// result and response registers.
// ----------------------------------------------------------------------------
module rqpd_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rqpd_pkg::req_t    req,
	input  rqpd_pkg::dp_cmd_t cmd,
	output rqpd_pkg::dp_stat_t stat,
	output rqpd_pkg::rsp_t    rsp
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	rqpd_pkg::entry_t mem [QUEUE_DEPTH];
	rqpd_pkg::entry_t rdata_q;
	rqpd_pkg::entry_t wr_entry;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] ptr_q;
	logic          pv_q;
	logic [IW-1:0] pidx_q;
	logic [IW-1:0] best_idx_q;
	logic [15:0]   best_key_q;
	logic [IW-1:0] raddr;
	logic          rd_en;
	logic [15:0]   key;
	logic          better;

	rqpd_pkg::status_t res_status_q;
	logic [7:0]        res_id_q;
	logic [15:0]       res_clocks_q;
	logic [7:0]        res_prio_q;
	rqpd_pkg::rsp_t    rsp_q;

	assign wr_entry = '{id: req.proc_id, clocks: req.est_clocks, prio: req.prio_level};
	assign rd_en    = cmd.rd_step | cmd.fetch_rd;
	assign raddr    = cmd.fetch_rd ? best_idx_q : ptr_q[IW-1:0];

	assign key    = cmd.cmp_min ? rdata_q.clocks : {8'd0, rdata_q.prio};
	assign better = cmd.cmp_min ? (key < best_key_q) : (key > best_key_q);

	assign stat.full        = (fill_q == CW'(QUEUE_DEPTH));
	assign stat.empty       = (fill_q == '0);
	assign stat.scan_last   = (ptr_q == (fill_q - 1'b1));
	assign stat.ptr_lt_fill = (ptr_q < fill_q);
	assign stat.pv          = pv_q;

	assign rsp = rsp_q;

	// Single write port: a tail append and a compaction move never coincide.
	always_ff @(posedge clk) begin
		if (cmd.enq_wr) begin
			mem[fill_q[IW-1:0]] <= wr_entry;
		end else if (cmd.shift_wr && pv_q) begin
			mem[IW'(pidx_q - 1'b1)] <= rdata_q;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
			pv_q   <= 1'b0;
		end else begin
			if (cmd.enq_wr) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.dec) begin
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.res_ld) begin
				ptr_q <= CW'(best_idx_q) + 1'b1;
			end else if (cmd.rd_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
			pv_q <= cmd.rd_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_step) begin
			pidx_q <= ptr_q[IW-1:0];
		end
		if (cmd.ptr_clr) begin
			best_idx_q <= '0;
		end else if (cmd.cmp && pv_q && ((pidx_q == '0) || better)) begin
			best_idx_q <= pidx_q;
			best_key_q <= key;
		end
		if (cmd.res_st_ld) begin
			res_status_q <= cmd.res_status;
			res_id_q     <= '0;
			res_clocks_q <= '0;
			res_prio_q   <= '0;
		end else if (cmd.res_ld) begin
			res_status_q <= rqpd_pkg::ST_OK;
			res_id_q     <= rdata_q.id;
			res_clocks_q <= rdata_q.clocks;
			res_prio_q   <= rdata_q.prio;
		end
		if (cmd.out_ld) begin
			rsp_q.status     <= res_status_q;
			rsp_q.out_id     <= res_id_q;
			rsp_q.out_clocks <= res_clocks_q;
			rsp_q.out_prio   <= res_prio_q;
			rsp_q.occupancy  <= 5'(fill_q);
		end
	end

endmodule

@@ rtl/rqpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqpd_ctrl: ready queue controller
// Sequences enqueue, scan, fetch, compaction and response delivery.
// ----------------------------------------------------------------------------
module rqpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               req_op,
	input  logic [1:0]         policy,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  rqpd_pkg::dp_stat_t stat,
	output rqpd_pkg::dp_cmd_t  cmd
);

	rqpd_pkg::state_t state_q;
	rqpd_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             rsp_valid_d;
	logic             do_scan;

	assign do_scan   = (policy == rqpd_pkg::POL_SHORTEST) || (policy == rqpd_pkg::POL_PRIO);
	assign req_ready = (state_q == rqpd_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rqpd_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		cmd         = '0;
		cmd.res_status = rqpd_pkg::ST_OK;
		cmd.cmp_min = (policy == rqpd_pkg::POL_SHORTEST);
		case (state_q)
			rqpd_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req_op == rqpd_pkg::OP_ENQ) begin
						cmd.res_st_ld  = 1'b1;
						cmd.res_status = stat.full ? rqpd_pkg::ST_FULL : rqpd_pkg::ST_OK;
						cmd.enq_wr     = !stat.full;
						state_d        = rqpd_pkg::S_RESP;
					end else if (stat.empty) begin
						cmd.res_st_ld  = 1'b1;
						cmd.res_status = rqpd_pkg::ST_EMPTY;
						state_d        = rqpd_pkg::S_RESP;
					end else begin
						cmd.ptr_clr = 1'b1;
						state_d     = do_scan ? rqpd_pkg::S_SCAN : rqpd_pkg::S_FETCH;
					end
				end
			end
			rqpd_pkg::S_SCAN: begin
				cmd.rd_step = 1'b1;
				cmd.cmp     = 1'b1;
				if (stat.scan_last) begin
					state_d = rqpd_pkg::S_SCAN_END;
				end
			end
			rqpd_pkg::S_SCAN_END: begin
				cmd.cmp = 1'b1;
				state_d = rqpd_pkg::S_FETCH;
			end
			rqpd_pkg::S_FETCH: begin
				cmd.fetch_rd = 1'b1;
				state_d      = rqpd_pkg::S_FETCH_W;
			end
			rqpd_pkg::S_FETCH_W: begin
				cmd.res_ld = 1'b1;
				state_d    = rqpd_pkg::S_SHIFT;
			end
			rqpd_pkg::S_SHIFT: begin
				cmd.rd_step  = stat.ptr_lt_fill;
				cmd.shift_wr = 1'b1;
				if (!stat.ptr_lt_fill && !stat.pv) begin
					cmd.dec = 1'b1;
					state_d = rqpd_pkg::S_RESP;
				end
			end
			rqpd_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_ld  = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = rqpd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rqpd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/ready_queue_policy_dispatch.sv @@
// ----------------------------------------------------------------------------
// ready_queue_policy_dispatch: ready queue with policy dispatch
// Holds process descriptors in arrival order; enqueue appends at the tail,
// dispatch removes one entry chosen by the configured policy.
// ----------------------------------------------------------------------------
//
// Channel   Signals                               Moves
// req       req_valid, req_ready, req (req_t)     enqueue or dispatch request
// rsp       rsp_valid, rsp_ready, rsp (rsp_t)     status, dispatched entry, occupancy
// cfg       psel, penable, pwrite, paddr, pwdata, policy register
//           prdata, pready
//
// An enqueue goes from acceptance straight to the response state. An
// oldest-first dispatch fetches the head entry and compacts the queue; the
// fewest-clocks and highest-priority policies first scan every queued entry,
// while compaction then moves only the entries behind the chosen one.
// The single read port and single write port of the entry memory pace both
// steps: the scan reads one entry per cycle and compaction moves one.
// Reset clears the fill count, the controller and the response valid; entry
// storage is not cleared. A response waiting for rsp_ready holds its register
// while the next request is accepted and processed; that request finishes only
// once the response register is free.
module ready_queue_policy_dispatch #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  rqpd_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output rqpd_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rqpd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [1:0]         policy_q;
	logic               reg_hit;
	rqpd_pkg::dp_cmd_t  cmd;
	rqpd_pkg::dp_stat_t stat;

	// The register decode looks at the word address only; the byte lanes
	// within a word all select the same register.
	assign reg_hit = (paddr[rqpd_pkg::ADDR_W-1:2] == rqpd_pkg::REG_POLICY);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= rqpd_pkg::POL_OLDEST;
		end else if (psel && penable && pwrite && reg_hit) begin
			policy_q <= pwdata[1:0];
		end
	end

	// The controller owns the sequencing; the datapath owns the entry memory
	// and every register that carries descriptor data.
	rqpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_op    (req.op),
		.policy    (policy_q),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rqpd_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

@@ dv/ready_queue_policy_dispatch_tb.sv @@
// ----------------------------------------------------------------------------
// ready_queue_policy_dispatch_tb: self-checking bench for the ready queue
// A short table of directed transactions covers empty and full queues, field
// extremes, every dispatch policy, the unused policy code and ties. About 1600
// random transactions follow, with random idling on both channels. A scoreboard
// model of the queue predicts every response that the table does not fix.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ready_queue_policy_dispatch_tb;

	localparam int QDEPTH         = 16;
	// Wait after the last expected response. It is sized from two passes
	// over a full queue, which covers the longest dispatch.
	localparam int TAIL_CYCLES    = 2 * QDEPTH + 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [rqpd_pkg::ADDR_W-1:0] POLICY_ADDR = {rqpd_pkg::REG_POLICY, 2'b00};

	// Directed table. A policy row writes the register once the block is idle.
	// A fill row enqueues patterned descriptors until the queue is full.
	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_POLICY,
		ROW_FILL
	} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic [1:0]     policy;
		logic           fixed;
		rqpd_pkg::req_t req;
		rqpd_pkg::rsp_t want;
	} plan_row_t;

	localparam int PLAN_LEN = 15;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// Dispatch from the empty queue; the ignored fields are all ones.
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_DISP, 8'hFF, 16'hFFFF, 8'hFF},
			'{rqpd_pkg::ST_EMPTY, 8'h00, 16'h0000, 8'h00, 5'd0}},
		// Field extremes, high then low.
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_ENQ, 8'hFF, 16'hFFFF, 8'hFF},
			'{rqpd_pkg::ST_OK, 8'h00, 16'h0000, 8'h00, 5'd1}},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_ENQ, 8'h00, 16'h0000, 8'h00},
			'{rqpd_pkg::ST_OK, 8'h00, 16'h0000, 8'h00, 5'd2}},
		// Oldest first returns the descriptors in arrival order.
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_DISP, 8'h5A, 16'hA5A5, 8'h3C},
			'{rqpd_pkg::ST_OK, 8'hFF, 16'hFFFF, 8'hFF, 5'd1}},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_DISP, 8'h00, 16'h0000, 8'h00},
			'{rqpd_pkg::ST_OK, 8'h00, 16'h0000, 8'h00, 5'd0}},
		'{ROW_POLICY, rqpd_pkg::POL_SHORTEST, 1'b0, '0, '0},
		'{ROW_FILL, rqpd_pkg::POL_OLDEST, 1'b0, '0, '0},
		// Enqueue into the full queue leaves it unchanged.
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b1,
			'{rqpd_pkg::OP_ENQ, 8'h77, 16'h0001, 8'hFF},
			'{rqpd_pkg::ST_FULL, 8'h00, 16'h0000, 8'h00, 5'd16}},
		// The fill pattern holds ties on the fewest clocks and on the top priority.
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b0,
			'{rqpd_pkg::OP_DISP, 8'h00, 16'h0000, 8'h00}, '0},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b0,
			'{rqpd_pkg::OP_DISP, 8'hC3, 16'h3CC3, 8'h81}, '0},
		'{ROW_POLICY, rqpd_pkg::POL_PRIO, 1'b0, '0, '0},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b0,
			'{rqpd_pkg::OP_DISP, 8'h00, 16'h0000, 8'h00}, '0},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b0,
			'{rqpd_pkg::OP_DISP, 8'hFF, 16'hFFFF, 8'hFF}, '0},
		// The unused policy code behaves as oldest first.
		'{ROW_POLICY, 2'd3, 1'b0, '0, '0},
		'{ROW_ITEM, rqpd_pkg::POL_OLDEST, 1'b0,
			'{rqpd_pkg::OP_DISP, 8'h00, 16'h0000, 8'h00}, '0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_ready;
	rqpd_pkg::req_t                req;
	logic                          rsp_valid;
	logic                          rsp_ready;
	rqpd_pkg::rsp_t                rsp;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [rqpd_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	// Scoreboard model: queued descriptors in arrival order and the policy.
	rqpd_pkg::entry_t ready_q[$];
	logic [1:0]       cur_policy;
	// Responses still owed by the block, oldest first.
	rqpd_pkg::rsp_t   pending_rsp[$];
	int               mismatch_cnt;
	// While set, neither side idles.
	bit               quiet;
	int               stall_left;
	int               idle_cycles;

	ready_queue_policy_dispatch #(
		.QUEUE_DEPTH(QDEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one transaction to the queue model and returns its response.
	// Ties go to the earliest entry because only a strict improvement moves
	// the pick.
	function automatic rqpd_pkg::rsp_t schedule_step(input rqpd_pkg::req_t r);
		rqpd_pkg::rsp_t   res;
		rqpd_pkg::entry_t ent;
		int               pick;
		res = '0;
		res.status = rqpd_pkg::ST_OK;
		if (r.op == rqpd_pkg::OP_ENQ) begin
			if (ready_q.size() >= QDEPTH) begin
				res.status = rqpd_pkg::ST_FULL;
			end else begin
				ent.id = r.proc_id;
				ent.clocks = r.est_clocks;
				ent.prio = r.prio_level;
				ready_q.insert(ready_q.size(), ent);
			end
		end else if (ready_q.size() == 0) begin
			res.status = rqpd_pkg::ST_EMPTY;
		end else begin
			pick = 0;
			for (int i = 1; i < ready_q.size(); i++) begin
				if (cur_policy == rqpd_pkg::POL_SHORTEST &&
					ready_q[i].clocks < ready_q[pick].clocks)
					pick = i;
				if (cur_policy == rqpd_pkg::POL_PRIO &&
					ready_q[i].prio > ready_q[pick].prio)
					pick = i;
			end
			res.out_id = ready_q[pick].id;
			res.out_clocks = ready_q[pick].clocks;
			res.out_prio = ready_q[pick].prio;
			ready_q.delete(pick);
		end
		res.occupancy = 5'(ready_q.size());
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Clocks lean toward a few small values, priorities toward a few large
	// ones, both toward the extremes, so ties and boundary compares come up often.
	function automatic rqpd_pkg::req_t rand_req(input int enq_pct);
		rqpd_pkg::req_t r;
		r.op = ($urandom_range(0, 99) < enq_pct) ? rqpd_pkg::OP_ENQ : rqpd_pkg::OP_DISP;
		r.proc_id = 8'($urandom());
		case ($urandom_range(0, 3))
			0: r.est_clocks = 16'($urandom_range(0, 3));
			1: r.est_clocks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: r.est_clocks = 16'($urandom());
		endcase
		case ($urandom_range(0, 3))
			0: r.prio_level = 8'($urandom_range(252, 255));
			1: r.prio_level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: r.prio_level = 8'($urandom());
		endcase
		return r;
	endfunction

	// Holds the transaction until it is accepted, then records its response.
	// Valid is left high so that a back-to-back transaction follows directly.
	task automatic send_item(input rqpd_pkg::req_t r, input bit fixed,
		input rqpd_pkg::rsp_t want);
		rqpd_pkg::rsp_t model_rsp;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		model_rsp = schedule_step(r);
		pending_rsp.insert(pending_rsp.size(), fixed ? want : model_rsp);
	endtask

	task automatic idle_gap();
		int n;
		n = pick_gap();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Lets every owed response come back, then lets the block settle.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Writes the policy register with random upper bits, then reads it back.
	task automatic write_policy(input logic [1:0] pol);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= POLICY_ADDR;
		pwdata <= {30'($urandom()), pol};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cur_policy = pol;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[1:0] !== pol) begin
			$display("%0t: policy readback expected %0d actual %0d", $time, pol, prdata[1:0]);
			mismatch_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Response side: check each accepted transaction and drive the stalls.
	always @(posedge clk) begin : rsp_side
		rqpd_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response: status %0d id %0d clocks %0d prio %0d occ %0d",
					$time, rsp.status, rsp.out_id, rsp.out_clocks, rsp.out_prio,
					rsp.occupancy);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						rsp.status);
					mismatch_cnt++;
				end
				if (rsp.out_id !== want.out_id) begin
					$display("%0t: out_id expected %0d actual %0d", $time, want.out_id,
						rsp.out_id);
					mismatch_cnt++;
				end
				if (rsp.out_clocks !== want.out_clocks) begin
					$display("%0t: out_clocks expected %0d actual %0d", $time,
						want.out_clocks, rsp.out_clocks);
					mismatch_cnt++;
				end
				if (rsp.out_prio !== want.out_prio) begin
					$display("%0t: out_prio expected %0d actual %0d", $time, want.out_prio,
						rsp.out_prio);
					mismatch_cnt++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time,
						want.occupancy, rsp.occupancy);
					mismatch_cnt++;
				end
			end
		end
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				stall_left <= pick_gap();
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// A hung handshake on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("ready_queue_policy_dispatch_tb: FAIL");
			$finish;
		end
	end

	initial begin
		rqpd_pkg::req_t r;
		int             k;
		int             enq_pct;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cur_policy = rqpd_pkg::POL_OLDEST;
		mismatch_cnt = 0;
		quiet = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		for (int n = 0; n < PLAN_LEN; n++) begin
			case (PLAN[n].kind)
				ROW_POLICY: begin
					wait_idle();
					write_policy(PLAN[n].policy);
				end
				ROW_FILL: begin
					while (ready_q.size() < QDEPTH) begin
						k = ready_q.size();
						r.op = rqpd_pkg::OP_ENQ;
						r.proc_id = 8'(8'h10 + k);
						r.est_clocks = (k % 3 == 2) ? 16'h0010 : 16'(16'h4000 + k);
						r.prio_level = (k % 4 == 3) ? 8'hC0 : 8'(k);
						send_item(r, 1'b0, '0);
						idle_gap();
					end
				end
				default: begin
					send_item(PLAN[n].req, PLAN[n].fixed, PLAN[n].want);
					idle_gap();
				end
			endcase
		end

		// Random part: eight phases, the first four on each policy code in turn and
		// the rest on a random one. Each segment leans toward filling, draining or
		// holding the queue, so the full and empty boundaries are crossed many times.
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_policy(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
			for (int seg = 0; seg < 8; seg++) begin
				quiet = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
				if ($urandom_range(0, 5) == 0)
					wait_idle();
				repeat (25) begin
					send_item(rand_req(enq_pct), 1'b0, '0);
					idle_gap();
				end
			end
		end

		wait_idle();
		if (mismatch_cnt == 0)
			$display("ready_queue_policy_dispatch_tb: PASS");
		else
			$display("ready_queue_policy_dispatch_tb: FAIL");
		$finish;
	end

endmodule
